// ----- hdl/bitmap_page_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Short forms for the concurrent checks that the allocator modules carry.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("bitmap_page_allocator: check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("bitmap_page_allocator: check failed");

`endif

// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared types, codes, reset values and helper functions of the allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// Default geometry of the managed RAM.
	localparam int unsigned NUM_PAGES_DEF  = 32768;
	localparam int unsigned PAGE_SHIFT_DEF = 12;

	// Width of one word of the used map.
	localparam int unsigned MAP_BITS = 64;

	// Reset values of the configuration registers.
	localparam logic [31:0] RAM_BASE_RST   = 32'h4000_0000;
	localparam logic [31:0] KERNEL_END_RST = 32'h4020_0000;
	localparam logic [31:0] HOLE_BASE_RST  = 32'h46ff_e000;
	localparam logic [31:0] HOLE_END_RST   = 32'h4720_0000;

	// Operation codes.
	typedef enum logic [1:0] {
		FUNC_INIT  = 2'd0,
		FUNC_ALLOC = 2'd1,
		FUNC_FREE  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_FREE      = 3'd1,
		ST_RANGE        = 3'd2,
		ST_MISALIGNED   = 3'd3,
		ST_ALREADY_FREE = 3'd4
	} status_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_RAM_BASE   = 2'd0,
		CFG_KERNEL_END = 2'd1,
		CFG_HOLE_BASE  = 2'd2,
		CFG_HOLE_END   = 2'd3
	} cfg_reg_t;

	// Request transaction.
	typedef struct packed {
		func_t       func;
		logic [31:0] address;
	} request_t;

	// Result transaction.
	typedef struct packed {
		logic [31:0] page_address;
		status_t     status;
		logic [15:0] used_count;
		logic [15:0] free_count;
	} result_t;

	// Lowest clear bit of a map word. Bit 6 of the answer is set when every
	// bit is set; otherwise bits 5:0 give the position.
	function automatic logic [6:0] find_zero(input logic [MAP_BITS-1:0] v);
		logic [6:0] r;
		r = 7'h40;
		for (int i = MAP_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = 7'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/bitmap_page_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Keeps one used bit per physical page in a word-wide map memory, with a
// summary memory of full words and a flag per group of full words, and
// serves init, allocate and free requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown on result for the single cycle in which done is
// high, and it cannot be held off. The result is shown in the cycle after the
// last busy cycle of the request. Free makes a range check, then a
// read-modify-write of the map and summary words; it ends after the check
// when the address is out of range or misaligned. Allocate searches the group
// flags one chunk of 64 at a time, then reads the summary, then reads the map
// and writes it back; when every page is used it ends after the last chunk of
// flags. Init works out the kernel range, the hole range and the page count,
// then writes one map word per cycle. After reset the block is busy while it
// clears the map and summary memories; configuration writes are taken at any
// time. Function code 3 is answered in the cycle after it is taken. busy is
// low in the cycle in which a result is shown, so a new request may start
// then.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int unsigned NUM_PAGES  = NUM_PAGES_DEF,
	parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  request_t    request,
	output logic        busy,
	output logic        done,
	output result_t     result,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Geometry of the map, the summary and the group flags.
	localparam int unsigned WORDS  = (NUM_PAGES + MAP_BITS - 1) / MAP_BITS;
	localparam int unsigned WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned GROUPS = (WORDS + MAP_BITS - 1) / MAP_BITS;
	localparam int unsigned GAW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int unsigned CHUNKS = (GROUPS + MAP_BITS - 1) / MAP_BITS;
	localparam int unsigned CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned TOPW   = CHUNKS * MAP_BITS;
	localparam int unsigned CW     = $clog2(NUM_PAGES + 1);
	localparam int unsigned BPW    = 32 - PAGE_SHIFT;
	localparam int unsigned PW     = ((BPW > CW) ? BPW : CW) + 2;
	localparam int unsigned IXW    = WAW + 6;

	localparam logic [31:0] OFS_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

	// Bits past the last page, past the last word and past the last group
	// count as used so that partial words read as full.
	localparam int unsigned PAGE_REM = NUM_PAGES % MAP_BITS;
	localparam int unsigned WORD_REM = WORDS % MAP_BITS;
	localparam logic [MAP_BITS-1:0] MAP_PAD = (PAGE_REM == 0) ? '0 :
		~((64'd1 << PAGE_REM) - 64'd1);
	localparam logic [MAP_BITS-1:0] SUM_PAD = (WORD_REM == 0) ? '0 :
		~((64'd1 << WORD_REM) - 64'd1);
	localparam logic [TOPW-1:0] TOP_ONE = TOPW'(1);
	localparam logic [TOPW-1:0] TOP_PAD = ~((TOP_ONE << GROUPS) - TOP_ONE);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_INIT_K = 10'b00_0000_0010,
		S_INIT_H = 10'b00_0000_0100,
		S_INIT_C = 10'b00_0000_1000,
		S_SWEEP  = 10'b00_0001_0000,
		S_A_TOP  = 10'b00_0010_0000,
		S_A_SUM  = 10'b00_0100_0000,
		S_A_MAP  = 10'b00_1000_0000,
		S_F_CHK  = 10'b01_0000_0000,
		S_F_MOD  = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	logic [31:0]       ram_base_q;
	logic [31:0]       kernel_end_q;
	logic [31:0]       hole_base_q;
	logic [31:0]       hole_end_q;
	logic [31:0]       addr_q;
	logic [CW-1:0]     kf_q;
	logic [CW-1:0]     ks_q;
	logic [CW-1:0]     hf_q;
	logic [CW-1:0]     hs_q;
	logic [CW-1:0]     used_q;
	logic [WAW-1:0]    sw_q;
	logic [63:0]       acc_q;
	logic              silent_q;
	logic [CHW-1:0]    ch_q;
	logic [GAW-1:0]    g_q;
	logic [WAW-1:0]    w_q;
	logic [5:0]        bit_q;
	logic [GROUPS-1:0] top_full_q;
	result_t           result_q;
	logic              done_q;

	// Memory ports.
	logic                map_we;
	logic [WAW-1:0]      map_waddr;
	logic [MAP_BITS-1:0] map_wdata;
	logic                map_re;
	logic [WAW-1:0]      map_raddr;
	logic [MAP_BITS-1:0] map_rd;
	logic                sum_we;
	logic [GAW-1:0]      sum_waddr;
	logic [MAP_BITS-1:0] sum_wdata;
	logic                sum_re;
	logic [GAW-1:0]      sum_raddr;
	logic [MAP_BITS-1:0] sum_rd;

	// Range calculator.
	logic [PW-1:0] base_page;
	logic [31:0]   rng_start;
	logic [31:0]   rng_end;
	logic [CW-1:0] rng_first;
	logic [CW-1:0] rng_stop;

	// Decode of each state.
	logic [CW-1:0]       init_count;
	logic [CW-1:0]       ovl_lo;
	logic [CW-1:0]       ovl_hi;
	logic [CW-1:0]       ovl;
	logic [31:0]         sw32;
	logic [MAP_BITS-1:0] sw_mask;
	logic [MAP_BITS-1:0] sw_pad;
	logic                sw_full;
	logic [MAP_BITS-1:0] sw_acc;
	logic                sw_last;
	logic                sw_grp_end;
	logic [GAW-1:0]      sw_g;
	logic [MAP_BITS-1:0] sw_sumpad;
	logic [TOPW-1:0]     top_vec;
	logic [MAP_BITS-1:0] chunk;
	logic [6:0]          tz;
	logic                top_hit;
	logic [31:0]         top_g32;
	logic [GAW-1:0]      top_g;
	logic                ch_last;
	logic [MAP_BITS-1:0] g_sumpad;
	logic [6:0]          sz;
	logic [31:0]         as_w32;
	logic [31:0]         w_q32;
	logic [MAP_BITS-1:0] w_pad;
	logic [6:0]          mz;
	logic                am_hit;
	logic [MAP_BITS-1:0] am_newm;
	logic                am_full;
	logic [MAP_BITS-1:0] am_newsum;
	logic                am_topfull;
	logic [31:0]         am_idx32;
	logic [31:0]         am_page;
	logic [PW-1:0]       fc_sp;
	logic                fc_oor;
	logic                fc_mis;
	logic [31:0]         fc_idx32;
	logic                fm_used;
	logic [CW-1:0]       used_inc;
	logic [CW-1:0]       used_dec;

	// Map word mask for page range [first, stop) at map word w.
	function automatic logic [MAP_BITS-1:0] range_mask(input logic [31:0] w,
			input logic [CW-1:0] first, input logic [CW-1:0] stop);
		logic [31:0]         fw;
		logic [31:0]         swd;
		logic [MAP_BITS-1:0] lo_m;
		logic [MAP_BITS-1:0] hi_m;
		fw  = 32'(first) >> 6;
		swd = 32'(stop) >> 6;
		if (w < fw) begin
			lo_m = '0;
		end else if (w == fw) begin
			lo_m = ~64'd0 << first[5:0];
		end else begin
			lo_m = ~64'd0;
		end
		if (w < swd) begin
			hi_m = ~64'd0;
		end else if (w == swd) begin
			hi_m = ~(~64'd0 << stop[5:0]);
		end else begin
			hi_m = '0;
		end
		return lo_m & hi_m;
	endfunction

	// Result transaction with both page counts.
	function automatic result_t make_result(input logic [31:0] page,
			input status_t status, input logic [CW-1:0] used);
		result_t     r;
		logic [31:0] used32;
		logic [31:0] free32;
		used32         = 32'(used);
		free32         = 32'(NUM_PAGES) - used32;
		r.page_address = page;
		r.status       = status;
		r.used_count   = used32[15:0];
		r.free_count   = free32[15:0];
		return r;
	endfunction

	// Used map, one word per 64 pages.
	bpa_ram #(
		.WIDTH (MAP_BITS),
		.DEPTH (WORDS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rd)
	);

	// Summary of full map words, one word per 64 map words.
	bpa_ram #(
		.WIDTH (MAP_BITS),
		.DEPTH (GROUPS)
	) u_summary (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (sum_re),
		.raddr (sum_raddr),
		.rdata (sum_rd)
	);

	// The kernel range is worked out first, then the hole.
	assign base_page = PW'(ram_base_q >> PAGE_SHIFT);
	assign rng_start = (state_q == S_INIT_H) ? hole_base_q : ram_base_q;
	assign rng_end   = (state_q == S_INIT_H) ? hole_end_q : kernel_end_q;

	bpa_range #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.PW         (PW),
		.CW         (CW)
	) u_range (
		.base_page  (base_page),
		.start_addr (rng_start),
		.end_addr   (rng_end),
		.first      (rng_first),
		.stop       (rng_stop)
	);

	// Pages reserved by init: both ranges less their overlap.
	assign ovl_lo     = (kf_q > hf_q) ? kf_q : hf_q;
	assign ovl_hi     = (ks_q < hs_q) ? ks_q : hs_q;
	assign ovl        = (ovl_hi > ovl_lo) ? (ovl_hi - ovl_lo) : '0;
	assign init_count = (ks_q - kf_q) + (hs_q - hf_q) - ovl;

	// Sweep: one map word written per cycle, summary words collected.
	assign sw32       = 32'(sw_q);
	assign sw_mask    = range_mask(sw32, kf_q, ks_q) | range_mask(sw32, hf_q, hs_q);
	assign sw_last    = (sw_q == WAW'(WORDS - 1));
	assign sw_pad     = sw_last ? MAP_PAD : '0;
	assign sw_full    = &(sw_mask | sw_pad);
	assign sw_acc     = ((sw32[5:0] == 6'd0) ? 64'd0 : acc_q) | (64'(sw_full) << sw32[5:0]);
	assign sw_grp_end = (&sw32[5:0]) || sw_last;
	assign sw_g       = sw32[GAW+5:6];
	assign sw_sumpad  = (sw_g == GAW'(GROUPS - 1)) ? SUM_PAD : '0;

	// Allocate: search the group flags one chunk of 64 per cycle.
	assign top_vec = TOP_PAD | TOPW'(top_full_q);
	assign chunk   = top_vec[ch_q*MAP_BITS +: MAP_BITS];
	assign tz      = find_zero(chunk);
	assign top_hit = !tz[6];
	assign top_g32 = (32'(ch_q) << 6) | 32'(tz[5:0]);
	assign top_g   = top_g32[GAW-1:0];
	assign ch_last = (ch_q == CHW'(CHUNKS - 1));

	// Allocate: lowest word with a free page in the chosen group.
	assign g_sumpad = (g_q == GAW'(GROUPS - 1)) ? SUM_PAD : '0;
	assign sz       = find_zero(sum_rd | g_sumpad);
	assign as_w32   = (32'(g_q) << 6) | 32'(sz[5:0]);

	// Allocate: lowest free page in that word, then update word and summary.
	assign w_q32      = 32'(w_q);
	assign w_pad      = (w_q == WAW'(WORDS - 1)) ? MAP_PAD : '0;
	assign mz         = find_zero(map_rd | w_pad);
	assign am_hit     = !mz[6];
	assign am_newm    = map_rd | (64'd1 << mz[5:0]);
	assign am_full    = &(am_newm | w_pad);
	assign am_newsum  = sum_rd | (64'd1 << w_q32[5:0]);
	assign am_topfull = &(am_newsum | g_sumpad);
	assign am_idx32   = (w_q32 << 6) | 32'(mz[5:0]);
	assign am_page    = (32'(base_page) + am_idx32) << PAGE_SHIFT;

	// Free: range check before the alignment check.
	assign fc_sp    = PW'(addr_q >> PAGE_SHIFT);
	assign fc_oor   = (fc_sp < base_page) || (fc_sp >= base_page + PW'(NUM_PAGES));
	assign fc_mis   = |(addr_q & OFS_MASK);
	assign fc_idx32 = 32'(fc_sp - base_page);
	assign fm_used  = map_rd[bit_q];

	assign used_inc = used_q + CW'(1);
	assign used_dec = used_q - CW'(1);

	// Memory port control.
	always_comb begin
		map_we    = 1'b0;
		map_waddr = w_q;
		map_wdata = am_newm;
		map_re    = 1'b0;
		map_raddr = w_q;
		sum_we    = 1'b0;
		sum_waddr = g_q;
		sum_wdata = am_newsum;
		sum_re    = 1'b0;
		sum_raddr = g_q;
		unique case (state_q)
			S_SWEEP: begin
				map_we    = 1'b1;
				map_waddr = sw_q;
				map_wdata = sw_mask;
				sum_we    = sw_grp_end;
				sum_waddr = sw_g;
				sum_wdata = sw_acc;
			end
			S_A_TOP: begin
				sum_re    = top_hit;
				sum_raddr = top_g;
			end
			S_A_SUM: begin
				map_re    = 1'b1;
				map_raddr = as_w32[WAW-1:0];
			end
			S_A_MAP: begin
				map_we = am_hit;
				sum_we = am_hit && am_full;
			end
			S_F_CHK: begin
				map_re    = !fc_oor && !fc_mis;
				map_raddr = fc_idx32[IXW-1:6];
				sum_re    = !fc_oor && !fc_mis;
				sum_raddr = fc_idx32[GAW+11:12];
			end
			S_F_MOD: begin
				map_we    = fm_used;
				map_wdata = map_rd & ~(64'd1 << bit_q);
				sum_we    = fm_used;
				sum_wdata = sum_rd & ~(64'd1 << w_q32[5:0]);
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base_q   <= RAM_BASE_RST;
			kernel_end_q <= KERNEL_END_RST;
			hole_base_q  <= HOLE_BASE_RST;
			hole_end_q   <= HOLE_END_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_RAM_BASE:   ram_base_q   <= cfg_data;
				CFG_KERNEL_END: kernel_end_q <= cfg_data;
				CFG_HOLE_BASE:  hole_base_q  <= cfg_data;
				CFG_HOLE_END:   hole_end_q   <= cfg_data;
			endcase
		end
	end

	// Sequencer; reset starts a silent sweep that clears both memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			silent_q   <= 1'b1;
			sw_q       <= '0;
			acc_q      <= '0;
			kf_q       <= '0;
			ks_q       <= '0;
			hf_q       <= '0;
			hs_q       <= '0;
			used_q     <= '0;
			top_full_q <= '0;
			ch_q       <= '0;
			g_q        <= '0;
			w_q        <= '0;
			bit_q      <= '0;
			addr_q     <= '0;
			result_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (request.func)
							FUNC_INIT: state_q <= S_INIT_K;
							FUNC_ALLOC: begin
								ch_q    <= '0;
								state_q <= S_A_TOP;
							end
							FUNC_FREE: begin
								addr_q  <= request.address;
								state_q <= S_F_CHK;
							end
							FUNC_NONE: begin
								result_q <= make_result('0, ST_OK, used_q);
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				S_INIT_K: begin
					kf_q    <= rng_first;
					ks_q    <= rng_stop;
					state_q <= S_INIT_H;
				end
				S_INIT_H: begin
					hf_q    <= rng_first;
					hs_q    <= rng_stop;
					state_q <= S_INIT_C;
				end
				S_INIT_C: begin
					used_q   <= init_count;
					sw_q     <= '0;
					silent_q <= 1'b0;
					state_q  <= S_SWEEP;
				end
				S_SWEEP: begin
					acc_q <= sw_acc;
					if (sw_grp_end) begin
						top_full_q[sw_g] <= &(sw_acc | sw_sumpad);
					end
					if (sw_last) begin
						if (!silent_q) begin
							result_q <= make_result('0, ST_OK, used_q);
							done_q   <= 1'b1;
						end
						state_q <= S_IDLE;
					end else begin
						sw_q <= sw_q + WAW'(1);
					end
				end
				S_A_TOP: begin
					if (top_hit) begin
						g_q     <= top_g;
						state_q <= S_A_SUM;
					end else if (ch_last) begin
						result_q <= make_result('0, ST_NO_FREE, used_q);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						ch_q <= ch_q + CHW'(1);
					end
				end
				S_A_SUM: begin
					w_q     <= as_w32[WAW-1:0];
					state_q <= S_A_MAP;
				end
				S_A_MAP: begin
					if (am_hit) begin
						used_q <= used_inc;
						if (am_full && am_topfull) begin
							top_full_q[g_q] <= 1'b1;
						end
						result_q <= make_result(am_page, ST_OK, used_inc);
					end else begin
						result_q <= make_result('0, ST_NO_FREE, used_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F_CHK: begin
					if (fc_oor) begin
						result_q <= make_result('0, ST_RANGE, used_q);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (fc_mis) begin
						result_q <= make_result('0, ST_MISALIGNED, used_q);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						w_q     <= fc_idx32[IXW-1:6];
						g_q     <= fc_idx32[GAW+11:12];
						bit_q   <= fc_idx32[5:0];
						state_q <= S_F_MOD;
					end
				end
				S_F_MOD: begin
					if (fm_used) begin
						used_q          <= used_dec;
						top_full_q[g_q] <= 1'b0;
						result_q        <= make_result('0, ST_OK, used_dec);
					end else begin
						result_q <= make_result('0, ST_ALREADY_FREE, used_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// The used count never exceeds the number of pages.
	`BPA_ASSERT_NOW(a_used_bound, clk, arst_n, 1'b1, used_q <= CW'(NUM_PAGES))
	// A request other than the empty code keeps the block busy next cycle.
	`BPA_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy && request.func != FUNC_NONE, busy)
	// Freeing a used page drops the count by one.
	`BPA_ASSERT_NEXT(a_free_count, clk, arst_n, state_q == S_F_MOD && fm_used, used_q == $past(used_q) - CW'(1))
	// An allocation that finds nothing returns a zero address.
	`BPA_ASSERT_NOW(a_oom_zero, clk, arst_n, done_q && result_q.status == ST_NO_FREE, result_q.page_address == 32'd0)
	// The map is written only by the sweep, an allocation or a free.
	`BPA_ASSERT_NOW(a_map_write, clk, arst_n, map_we, state_q == S_SWEEP || state_q == S_A_MAP || state_q == S_F_MOD)

endmodule

// ----- hdl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds until the
// next read.
// ----------------------------------------------------------------------------
module bpa_ram
	import bpa_pkg::*;
#(
	parameter int unsigned WIDTH = MAP_BITS,
	parameter int unsigned DEPTH = NUM_PAGES_DEF / MAP_BITS,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/bpa_range.sv -----
// ----------------------------------------------------------------------------
// Reserve range calculator
// Turns a byte range into a page index range of the managed RAM, clipped to
// the RAM and widened to whole pages. An empty answer is first = stop = 0.
// ----------------------------------------------------------------------------
module bpa_range
	import bpa_pkg::*;
#(
	parameter int unsigned NUM_PAGES  = NUM_PAGES_DEF,
	parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF,
	parameter int unsigned PW         = 24,
	parameter int unsigned CW         = 16
) (
	input  logic [PW-1:0] base_page,
	input  logic [31:0]   start_addr,
	input  logic [31:0]   end_addr,
	output logic [CW-1:0] first,
	output logic [CW-1:0] stop
);

	localparam logic [31:0]   OFS_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;
	localparam logic [PW-1:0] PAGES    = PW'(NUM_PAGES);

	logic [PW-1:0] start_page;
	logic [PW-1:0] end_ceil;
	logic [PW-1:0] limit_page;
	logic [PW-1:0] lo;
	logic [PW-1:0] hi;
	logic          hit;

	// Page numbers of both ends, the end rounded up to a page bound.
	assign start_page = PW'(start_addr >> PAGE_SHIFT);
	assign end_ceil   = PW'(end_addr >> PAGE_SHIFT) + PW'(|(end_addr & OFS_MASK));
	assign limit_page = base_page + PAGES;

	// Clip to the RAM and drop ranges that miss it or are empty.
	assign lo  = (start_page > base_page) ? start_page : base_page;
	assign hi  = (end_ceil < limit_page) ? end_ceil : limit_page;
	assign hit = (end_ceil > base_page) && (start_page < limit_page) && (hi > lo);

	assign first = hit ? CW'(lo - base_page) : '0;
	assign stop  = hit ? CW'(hi - base_page) : '0;

endmodule
